// File: sv/s2u_pkg.sv
// Shared types, constants and the character classifier of the string-to-unsigned parser.
`timescale 1ns / 1ps
package s2u_pkg;

  localparam int unsigned MAX_CHARS = 256;
  localparam int unsigned LIMIT     = (MAX_CHARS < 255) ? MAX_CHARS : 255;
  localparam int unsigned BASE_MAX  = 36;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned BASE_W    = 6;
  localparam int unsigned IDX_W     = 8;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] DIGIT_BAD = 6'd63;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Register byte address of radix_select
  localparam logic [2:0] REG_RADIX = 3'd0;

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_PRE  = 3'd1,
    PH_ZERO = 3'd2,
    PH_XPFX = 3'd3,
    PH_DIG  = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [ACC_W-1:0]   acc;
    logic               neg;
    logic               digit_seen;
    logic               saturated;
    logic [BASE_W-1:0]  active_base;
    logic [IDX_W-1:0]   char_index;
    logic [IDX_W-1:0]   stop_index;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_WS, acc: '0, neg: 1'b0, digit_seen: 1'b0, saturated: 1'b0,
    active_base: '0, char_index: '0, stop_index: '0
  };

  // Digit value of a character; DIGIT_BAD is above every legal base.
  function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'hFF;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd10;
      else if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41 + 8'd10;
      digit_of = (v == 8'hFF) ? DIGIT_BAD : v[BASE_W-1:0];
    end
  endfunction

endpackage

// File: sv/s2u_step.sv
// Next parse state for one character: phase logic plus the digit multiply-add.
`timescale 1ns / 1ps
module s2u_step (
  input  s2u_pkg::parse_state_t        st_i,
  input  logic [7:0]                   ch_i,
  input  logic [s2u_pkg::BASE_W-1:0]   radix_i,
  output s2u_pkg::parse_state_t        st_o
);
  import s2u_pkg::*;

  logic [BASE_W-1:0]  dig;
  logic               is_ws;
  logic               do_prefix;
  logic               do_digit;
  logic [ACC_W+6:0]   mac;
  parse_state_t       nx;

  assign dig   = digit_of(ch_i);
  assign is_ws = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_CR) ||
                 (ch_i == CH_LF) || (ch_i == CH_FF);

  always_comb begin
    nx        = st_i;
    do_prefix = 1'b0;
    do_digit  = 1'b0;
    mac       = '0;
    if (st_i.char_index >= IDX_W'(LIMIT)) begin
      // past the length limit: acts as a terminator
      nx.phase = PH_DONE;
    end else begin
      nx.char_index = st_i.char_index + 1'b1;
      case (st_i.phase)
        PH_WS: begin
          if (!is_ws) begin
            if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
              nx.neg   = (ch_i == CH_MINUS);
              nx.phase = PH_PRE;
            end else begin
              do_prefix = 1'b1;
            end
          end
        end
        PH_PRE: do_prefix = 1'b1;
        PH_ZERO: begin
          if (ch_i == CH_X_LO || ch_i == CH_X_UP) begin
            nx.active_base = BASE_HEX;
            nx.phase       = PH_XPFX;
          end else begin
            if (st_i.active_base == BASE_AUTO) nx.active_base = BASE_OCT;
            nx.phase = PH_DIG;
            do_digit = 1'b1;
          end
        end
        PH_XPFX, PH_DIG: begin
          nx.phase = PH_DIG;
          do_digit = 1'b1;
        end
        default: ;
      endcase

      if (do_prefix) begin
        if (radix_i > BASE_W'(BASE_MAX)) begin
          nx.phase = PH_DONE;
        end else if ((radix_i == BASE_AUTO || radix_i == BASE_HEX) && ch_i == CH_ZERO) begin
          // leading zero counts as a digit; may open a hex prefix
          nx.active_base = radix_i;
          nx.digit_seen  = 1'b1;
          nx.stop_index  = st_i.char_index + 1'b1;
          nx.phase       = PH_ZERO;
        end else begin
          nx.active_base = (radix_i == BASE_AUTO) ? BASE_DEC : radix_i;
          nx.phase       = PH_DIG;
          do_digit       = 1'b1;
        end
      end

      if (do_digit) begin
        mac = (ACC_W+7)'(st_i.acc) * (ACC_W+7)'(nx.active_base) + (ACC_W+7)'(dig);
        if (nx.active_base == BASE_AUTO || dig >= nx.active_base) begin
          nx.phase = PH_DONE;
        end else if (mac[ACC_W+6:ACC_W] != '0) begin
          nx.acc       = '1;
          nx.saturated = 1'b1;
          nx.phase     = PH_DONE;
        end else begin
          nx.acc        = mac[ACC_W-1:0];
          nx.digit_seen = 1'b1;
          nx.stop_index = st_i.char_index + 1'b1;
        end
      end
    end
  end

  assign st_o = nx;

endmodule

// File: sv/string_to_unsigned_parser_unit.sv
// Top level: streaming string-to-unsigned parser with APB radix register.
// out_valid_o rises in the cycle after the beat marked last is consumed; a last beat waits
//   in the input register only while an unread result still holds the result register.
// Throughput: one character beat per cycle unless a last beat waits; each beat passes the
//   input register, then one 64x6 multiply-add and phase update closing the per-string loop.
// Reset: rst_ni is asynchronous, active low; clears radix_select to 0, the parse state to the
//   whitespace phase, and both the input and result registers to empty.
`timescale 1ns / 1ps
module string_to_unsigned_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // character beats
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   ch_i,
  input  logic         last_i,
  // result beats
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  value_o,
  output logic [7:0]   end_offset_o,
  output logic         no_digits_o,
  output logic         overflow_o
);
  import s2u_pkg::*;

  // ---------------------------------------------------------------- config
  logic [BASE_W-1:0] radix_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // only the word at byte address 0 is implemented; low byte-lane bits ignored
  assign prdata = (paddr[2] == REG_RADIX[2]) ? {26'd0, radix_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= BASE_AUTO;
    end else if (cfg_wr && paddr[2] == REG_RADIX[2]) begin
      radix_q <= pwdata[BASE_W-1:0];
    end
  end

  // ---------------------------------------------------------- input stage
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       adv;      // beat in input register is consumed this cycle
  logic       out_valid_q;

  // a non-last beat never waits; a last beat needs room in the result register
  assign adv        = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  // ----------------------------------------------------------- parse loop
  parse_state_t st_q;
  parse_state_t st_d;

  s2u_step u_step (
    .st_i    (st_q),
    .ch_i    (ch_q),
    .radix_i (radix_q),
    .st_o    (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_CLEAR;
    end else if (adv) begin
      // end of string: start the next string from scratch
      st_q <= last_q ? STATE_CLEAR : st_d;
    end
  end

  // --------------------------------------------------------- result stage
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] value_d;
  logic [63:0]      value_q;
  logic [7:0]       end_offset_q;
  logic             no_digits_q;
  logic             overflow_q;

  assign mag     = st_d.saturated ? '1 : st_d.acc;
  assign value_d = st_d.neg ? (ACC_W'(0) - mag) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      value_q      <= value_d;
      end_offset_q <= st_d.digit_seen ? st_d.stop_index : 8'd0;
      no_digits_q  <= !st_d.digit_seen;
      overflow_q   <= st_d.saturated;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = end_offset_q;
  assign no_digits_o  = no_digits_q;
  assign overflow_o   = overflow_q;

`ifndef ASSERT_OFF
  // saturation always leaves the accumulator at all ones
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.saturated |-> (st_q.acc == '1 && st_q.phase == PH_DONE))
    else $error("saturated without all-ones accumulator");

  // the end offset never runs ahead of the characters seen
  a_stop_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.digit_seen |-> (st_q.stop_index != '0 && st_q.stop_index <= st_q.char_index))
    else $error("stop index out of range");

  // consuming a last beat clears the per-string state
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (st_q.char_index == '0 && !st_q.digit_seen && st_q.phase == PH_WS))
    else $error("state not cleared after end of string");

  // a result appears only after a last beat was consumed
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && last_q))
    else $error("result without end of string");
`endif

endmodule
